// ===== hdl/iss_pkg.sv =====
// Shared types and constants for the 3x3 smooth/sharpen image filter.
// No dependencies; every other file in hdl/ except iss_ram imports this package.
package iss_pkg;

   localparam int PIXEL_W        = 8;
   localparam int LINE_W         = 2 * PIXEL_W;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 16;
   localparam int MIN_DIM        = 3;
   localparam int MAX_HEIGHT     = 65534;
   localparam int BOX_W          = 12;
   localparam int SHARP_W        = 13;

   // floor(s / 9) == (s * 7282) >> 16 for every box sum below 32768
   localparam int RECIP_W        = 13;
   localparam int RECIP_SHIFT    = 16;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

   localparam int DEF_FRAME_WIDTH  = 640;
   localparam int DEF_FRAME_HEIGHT = 480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE         = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_SMOOTH  = 1'b0,
      MODE_SHARPEN = 1'b1
   } mode_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   // per-item position decisions handed from the counters to the window stage
   typedef struct packed {
      logic emit;
      logic first_col;
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } border_type;

   // kernel partial results handed from the window stage to the output stage
   typedef struct packed {
      logic [BOX_W-1:0]   box;
      logic [SHARP_W-1:0] sharp;
      logic               last;
   } sum_type;

endpackage

// ===== hdl/iss_if.sv =====
// Valid/ready channel interfaces for the filter's pixel input and result output.
// Depends on iss_pkg for the payload widths.
interface iss_req_if import iss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               op;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, op, pixel, input ready);
   modport sink   (input valid, op, pixel, output ready);
endinterface

interface iss_rsp_if import iss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] value;
   logic               last;

   modport source (output valid, value, last, input ready);
   modport sink   (input valid, value, last, output ready);
endinterface

// ===== hdl/iss_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module iss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/iss_pos.sv =====
// Position counters of the filter: input column/row, output column/row.
// Decides per transfer the line address, the padded pixel and the border flags.
// Depends on iss_pkg.
module iss_pos import iss_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int AW       = $clog2(MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      op,
   input  logic [PIXEL_W-1:0]        pixel,
   input  logic [FRAME_WIDTH_W-1:0]  frame_width,
   input  logic [FRAME_HEIGHT_W-1:0] frame_height,
   output logic [AW-1:0]             col,
   output logic [PIXEL_W-1:0]        x,
   output border_type                flags
);

   localparam int WW = (AW + 1 > FRAME_WIDTH_W) ? AW + 1 : FRAME_WIDTH_W;
   localparam logic [WW-1:0] W_MIN = WW'(MIN_DIM);
   localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
   localparam logic [FRAME_HEIGHT_W-1:0] H_MIN = FRAME_HEIGHT_W'(MIN_DIM);
   localparam logic [FRAME_HEIGHT_W-1:0] H_MAX = FRAME_HEIGHT_W'(MAX_HEIGHT);

   logic [AW-1:0]             in_col_ff,  in_col_in;
   logic [FRAME_HEIGHT_W-1:0] in_row_ff,  in_row_in;
   logic [AW-1:0]             out_col_ff, out_col_in;
   logic [FRAME_HEIGHT_W-1:0] out_row_ff, out_row_in;

   logic [WW-1:0]             fw;
   logic [WW-1:0]             eff_w;
   logic [FRAME_HEIGHT_W-1:0] eff_h;
   logic                      in_wrap;
   logic [FRAME_HEIGHT_W-1:0] in_row_inc;
   logic [FRAME_HEIGHT_W-1:0] out_row_inc;

   // saturate the frame size to the supported range
   always_comb begin
      fw = WW'(frame_width);
      if (fw < W_MIN) begin
         eff_w = W_MIN;
      end else if (fw > W_MAX) begin
         eff_w = W_MAX;
      end else begin
         eff_w = fw;
      end
      if (frame_height < H_MIN) begin
         eff_h = H_MIN;
      end else if (frame_height > H_MAX) begin
         eff_h = H_MAX;
      end else begin
         eff_h = frame_height;
      end
   end

   // decisions for the item on the input side
   always_comb begin
      col     = in_col_ff;
      x       = (op == OP_PIXEL && in_row_ff < eff_h) ? pixel : '0;
      in_wrap = (WW'(in_col_ff) + WW'(1)) >= eff_w;

      flags.emit      = (in_row_ff >= FRAME_HEIGHT_W'(2)) ||
                        (in_row_ff == FRAME_HEIGHT_W'(1) && in_col_ff != '0);
      flags.first_col = (in_col_ff == '0);
      flags.top       = (out_row_ff == '0);
      flags.bottom    = ({1'b0, out_row_ff} + (FRAME_HEIGHT_W + 1)'(1)) >= {1'b0, eff_h};
      flags.left      = (out_col_ff == '0);
      flags.right     = (WW'(out_col_ff) + WW'(1)) >= eff_w;
      flags.last      = flags.bottom && flags.right;

      in_row_inc  = (in_row_ff == '1)  ? in_row_ff  : in_row_ff + FRAME_HEIGHT_W'(1);
      out_row_inc = (out_row_ff == '1) ? out_row_ff : out_row_ff + FRAME_HEIGHT_W'(1);
   end

   // advance the counters; the end of the frame returns them all to zero
   always_comb begin
      in_col_in  = in_wrap ? '0 : in_col_ff + AW'(1);
      in_row_in  = in_wrap ? in_row_inc : in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (flags.emit) begin
         priority if (flags.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (flags.right) begin
            out_col_in = '0;
            out_row_in = out_row_inc;
         end else begin
            out_col_in = out_col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ===== hdl/iss_win.sv =====
// Line memory and 3x3 window stage: read-modify-write of the two line buffers,
// window shift, border masking and the kernel sums. Depends on iss_pkg, iss_ram.
module iss_win import iss_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int AW       = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [AW-1:0]      col,
   input  logic [PIXEL_W-1:0] x,
   input  border_type         flags,
   output logic               take_ready,
   input  logic               sum_ready,
   output logic               sum_valid,
   output sum_type            sums
);

   // line stage registers
   logic               s1_v_ff;
   logic [AW-1:0]      s1_col_ff;
   logic [PIXEL_W-1:0] s1_x_ff;
   border_type         s1_flags_ff;
   logic               fwd_ff;
   logic [LINE_W-1:0]  fwd_data_ff;

   logic [PIXEL_W-1:0] win_ff [3][3];
   logic               sum_v_ff;
   sum_type            sum_ff;

   logic               s2_en;
   logic               s1_adv;
   logic [LINE_W-1:0]  ram_rd;
   logic [LINE_W-1:0]  rd_line;
   logic [LINE_W-1:0]  wr_line;
   logic [PIXEL_W-1:0] colv [3];
   logic [PIXEL_W-1:0] nb [3][3];
   logic [BOX_W-1:0]   box;
   logic [SHARP_W-1:0] sharp;

   // stage enables with bubble removal
   assign s2_en      = !sum_v_ff || sum_ready;
   assign take_ready = !s1_v_ff || s2_en;
   assign s1_adv     = s1_v_ff && s2_en;

   // upper line in the high byte, middle line in the low byte
   iss_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (col),
      .rd_data (ram_rd)
   );

   // take forwarded data when the previous item wrote this entry on the read edge
   always_comb begin
      rd_line = fwd_ff ? fwd_data_ff : ram_rd;
      colv[0] = rd_line[LINE_W-1:PIXEL_W];
      colv[1] = rd_line[PIXEL_W-1:0];
      colv[2] = s1_x_ff;
      wr_line = {colv[1], s1_x_ff};
   end

   // neighbourhood of the result; on the first column it is the previous row's end
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         nb[r][0] = win_ff[r][1];
         nb[r][1] = win_ff[r][2];
         nb[r][2] = s1_flags_ff.first_col ? '0 : colv[r];
      end
      for (int c = 0; c < 3; c++) begin
         if (s1_flags_ff.top) begin
            nb[0][c] = '0;
         end
         if (s1_flags_ff.bottom) begin
            nb[2][c] = '0;
         end
      end
      for (int r = 0; r < 3; r++) begin
         if (s1_flags_ff.left) begin
            nb[r][0] = '0;
         end
         if (s1_flags_ff.right) begin
            nb[r][2] = '0;
         end
      end
   end

   // box sum and sharpening sum (two's complement, wide enough for both extremes)
   always_comb begin
      box = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            box = box + BOX_W'(nb[r][c]);
         end
      end
      sharp = SHARP_W'({nb[1][1], 3'b000}) + SHARP_W'(nb[1][1])
            - SHARP_W'(nb[1][0])
            - (SHARP_W'({nb[1][2], 1'b0}) + SHARP_W'(nb[1][2]))
            - (SHARP_W'({nb[0][1], 1'b0}) + SHARP_W'(nb[0][1]))
            - SHARP_W'(nb[2][1]);
   end

   // line stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (take_ready) begin
         s1_v_ff <= accept;
      end
   end

   // line stage payload and forwarding capture
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= col;
         s1_x_ff     <= x;
         s1_flags_ff <= flags;
         fwd_ff      <= s1_v_ff && (s1_col_ff == col);
         fwd_data_ff <= wr_line;
      end
   end

   // shift the window; clear it at the end of the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (s1_adv) begin
         for (int r = 0; r < 3; r++) begin
            if (s1_flags_ff.emit && s1_flags_ff.last) begin
               win_ff[r][0] <= '0;
               win_ff[r][1] <= '0;
               win_ff[r][2] <= '0;
            end else begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
               win_ff[r][2] <= colv[r];
            end
         end
      end
   end

   // sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
      end else if (s2_en) begin
         sum_v_ff <= s1_v_ff && s1_flags_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         sum_ff.box   <= box;
         sum_ff.sharp <= sharp;
         sum_ff.last  <= s1_flags_ff.last;
      end
   end

   assign sum_valid = sum_v_ff;
   assign sums      = sum_ff;

endmodule

// ===== hdl/iss_kernel.sv =====
// Output stage: divide the box sum by nine or clamp the sharpening sum,
// then hold the result in the output register. Depends on iss_pkg, iss_if.
module iss_kernel import iss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  mode_type  mode,
   input  logic      sum_valid,
   input  sum_type   sums,
   output logic      sum_ready,
   iss_rsp_if.source rsp
);

   localparam int PROD_W = BOX_W + RECIP_W;

   logic               out_v_ff;
   logic [PIXEL_W-1:0] value_ff;
   logic               last_ff;

   logic [PROD_W-1:0]  box_prod;
   logic [PIXEL_W-1:0] box_avg;
   logic [PIXEL_W-1:0] sharp_clamped;
   logic [PIXEL_W-1:0] value_in;

   assign sum_ready = !out_v_ff || rsp.ready;

   // divide by nine through the reciprocal, clamp the sharpened value
   always_comb begin
      box_prod = PROD_W'(sums.box) * PROD_W'(RECIP_NINE);
      box_avg  = box_prod[RECIP_SHIFT +: PIXEL_W];
      priority if (sums.sharp[SHARP_W-1]) begin
         sharp_clamped = '0;
      end else if (|sums.sharp[SHARP_W-2:PIXEL_W]) begin
         sharp_clamped = '1;
      end else begin
         sharp_clamped = sums.sharp[PIXEL_W-1:0];
      end
      value_in = (mode == MODE_SHARPEN) ? sharp_clamped : box_avg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (sum_ready) begin
         out_v_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && sum_valid) begin
         value_ff <= value_in;
         last_ff  <= sums.last;
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.value = value_ff;
   assign rsp.last  = last_ff;

endmodule

// ===== hdl/image_3x3_smooth_sharpen_unit.sv =====
// 3x3 smoothing / sharpening filter over a raster-order 8-bit grey stream.
// Throughput: one transfer per cycle while rsp_bus is not stalled, set by the single
// line-memory read-modify-write. A result passes the line, sum and output stage registers
// after the transfer that completes its neighbourhood, frame_width+1 places after its pixel.
// Reset (synchronous): counters, window and pipeline cleared, registers to defaults;
// the line memory is not cleared, stale rows are masked by the border padding.
module image_3x3_smooth_sharpen_unit import iss_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   iss_req_if.sink                req_bus,
   iss_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   mode_type                  mode_ff;
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   logic               accept;
   logic               take_ready;
   logic [AW-1:0]      col;
   logic [PIXEL_W-1:0] x;
   border_type         flags;
   logic               sum_valid;
   logic               sum_ready;
   sum_type            sums;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_SMOOTH;
         frame_width_ff  <= FRAME_WIDTH_W'(DEF_FRAME_WIDTH);
         frame_height_ff <= FRAME_HEIGHT_W'(DEF_FRAME_HEIGHT);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:         mode_ff         <= mode_type'(csr_data[0]);
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FRAME_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // input transfer
   assign req_bus.ready = take_ready;
   assign accept        = req_bus.valid && take_ready;

   iss_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_bus.op),
      .pixel        (req_bus.pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .col          (col),
      .x            (x),
      .flags        (flags)
   );

   iss_win #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_win (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .col        (col),
      .x          (x),
      .flags      (flags),
      .take_ready (take_ready),
      .sum_ready  (sum_ready),
      .sum_valid  (sum_valid),
      .sums       (sums)
   );

   iss_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .sum_valid (sum_valid),
      .sums      (sums),
      .sum_ready (sum_ready),
      .rsp       (rsp_bus)
   );

endmodule
